// ===== hdl/qrr_pkg.sv =====
// Package for the quadratic real roots core: widths, status codes, side-band types.
// Holds the saturation helper for the divider results. No dependencies.
package qrr_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int MAG_W  = DATA_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DISC_W = PROD_W + 2;
  localparam int ROOT_W = DISC_W / 2;
  localparam int SREM_W = ROOT_W + 3;
  localparam int NEGB_W = MAG_W + 1;
  localparam int NUM_W  = ROOT_W + 2;
  localparam int NMAG_W = NUM_W - 1;
  localparam int QUO_W  = NMAG_W + FRAC_W;
  localparam int DEN_W  = MAG_W + 1;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_DEGEN = 2'd3
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic                      a_neg;
    logic [MAG_W-1:0]          a_mag;
    logic signed [NEGB_W-1:0]  negb;
  } sq_side_t;

  typedef struct packed {
    status_t status;
    logic    neg_plus;
    logic    neg_minus;
  } dv_side_t;

  function automatic logic [DATA_W-1:0] sat_root(logic [QUO_W-1:0] q, logic neg);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] m;
    lim = (QUO_W'(1) << (DATA_W - 1)) - (neg ? QUO_W'(0) : QUO_W'(1));
    m   = (q > lim) ? lim : q;
    return neg ? (~m[DATA_W-1:0] + 1'b1) : m[DATA_W-1:0];
  endfunction

endpackage

// ===== hdl/qrr_sqrt.sv =====
// Pipelined truncating square root, one result bit per register stage.
// Depends on qrr_pkg for widths and the side-band type carried along.
module qrr_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_in,
  input  logic [qrr_pkg::DISC_W-1:0]    d_in,
  input  qrr_pkg::sq_side_t             side_in,
  output logic                          v_out,
  output logic [qrr_pkg::ROOT_W-1:0]    s_out,
  output qrr_pkg::sq_side_t             side_out
);

  localparam int N = qrr_pkg::ROOT_W;

  logic                          v_r    [N+1];
  logic [qrr_pkg::DISC_W-1:0]    dl_r   [N+1];
  logic [qrr_pkg::SREM_W-1:0]    rem_r  [N+1];
  logic [qrr_pkg::ROOT_W-1:0]    root_r [N+1];
  qrr_pkg::sq_side_t             side_r [N+1];

  logic [qrr_pkg::DISC_W-1:0]    dl_nxt   [N];
  logic [qrr_pkg::SREM_W-1:0]    rem_nxt  [N];
  logic [qrr_pkg::ROOT_W-1:0]    root_nxt [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic [qrr_pkg::SREM_W-1:0] rs;
      logic [qrr_pkg::SREM_W-1:0] tr;
      rs = {rem_r[i][qrr_pkg::SREM_W-3:0], dl_r[i][qrr_pkg::DISC_W-1 -: 2]};
      tr = {{(qrr_pkg::SREM_W - qrr_pkg::ROOT_W - 2){1'b0}}, root_r[i], 2'b01};
      dl_nxt[i] = dl_r[i] << 2;
      if (rs >= tr) begin
        rem_nxt[i]  = rs - tr;
        root_nxt[i] = {root_r[i][qrr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = rs;
        root_nxt[i] = {root_r[i][qrr_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int i = 0; i < N; i++) v_r[i+1] <= v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0]   <= d_in;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= side_in;
      for (int i = 0; i < N; i++) begin
        dl_r[i+1]   <= dl_nxt[i];
        rem_r[i+1]  <= rem_nxt[i];
        root_r[i+1] <= root_nxt[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign v_out    = v_r[N];
  assign s_out    = root_r[N];
  assign side_out = side_r[N];

endmodule

// ===== hdl/qrr_div.sv =====
// Pipelined dual restoring divider, one quotient bit per stage for both roots.
// Depends on qrr_pkg for widths and the side-band type carried along.
module qrr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_in,
  input  logic [qrr_pkg::QUO_W-1:0]     np_in,
  input  logic [qrr_pkg::QUO_W-1:0]     nm_in,
  input  logic [qrr_pkg::DEN_W-1:0]     den_in,
  input  qrr_pkg::dv_side_t             side_in,
  output logic                          v_out,
  output logic [qrr_pkg::QUO_W-1:0]     qp_out,
  output logic [qrr_pkg::QUO_W-1:0]     qm_out,
  output qrr_pkg::dv_side_t             side_out
);

  localparam int N = qrr_pkg::QUO_W;
  localparam int DW = qrr_pkg::DEN_W;

  logic                        v_r    [N+1];
  logic [N-1:0]                np_r   [N+1];
  logic [N-1:0]                nm_r   [N+1];
  logic [DW-1:0]               rp_r   [N+1];
  logic [DW-1:0]               rm_r   [N+1];
  logic [DW-1:0]               den_r  [N+1];
  qrr_pkg::dv_side_t           side_r [N+1];

  logic [N-1:0]                np_nxt [N];
  logic [N-1:0]                nm_nxt [N];
  logic [DW-1:0]               rp_nxt [N];
  logic [DW-1:0]               rm_nxt [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic [DW:0] p2;
      logic [DW:0] m2;
      logic [DW:0] dd;
      dd = {1'b0, den_r[i]};
      p2 = {rp_r[i], np_r[i][N-1]};
      m2 = {rm_r[i], nm_r[i][N-1]};
      if (p2 >= dd) begin
        rp_nxt[i] = DW'(p2 - dd);
        np_nxt[i] = {np_r[i][N-2:0], 1'b1};
      end else begin
        rp_nxt[i] = p2[DW-1:0];
        np_nxt[i] = {np_r[i][N-2:0], 1'b0};
      end
      if (m2 >= dd) begin
        rm_nxt[i] = DW'(m2 - dd);
        nm_nxt[i] = {nm_r[i][N-2:0], 1'b1};
      end else begin
        rm_nxt[i] = m2[DW-1:0];
        nm_nxt[i] = {nm_r[i][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int i = 0; i < N; i++) v_r[i+1] <= v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np_r[0]   <= np_in;
      nm_r[0]   <= nm_in;
      rp_r[0]   <= '0;
      rm_r[0]   <= '0;
      den_r[0]  <= den_in;
      side_r[0] <= side_in;
      for (int i = 0; i < N; i++) begin
        np_r[i+1]   <= np_nxt[i];
        nm_r[i+1]   <= nm_nxt[i];
        rp_r[i+1]   <= rp_nxt[i];
        rm_r[i+1]   <= rm_nxt[i];
        den_r[i+1]  <= den_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign v_out    = v_r[N];
  assign qp_out   = np_r[N];
  assign qm_out   = nm_r[N];
  assign side_out = side_r[N];

endmodule

// ===== hdl/quadratic_real_roots_core.sv =====
// Top level of the quadratic real roots core: products, discriminant, root, division.
// Depends on qrr_pkg, qrr_sqrt and qrr_div.
//
// Usage: the input channel takes one beat of signed Q15.16 coefficients a, b and c
// with valid and ready; the result channel delivers one beat per input with a
// status code and two saturated Q15.16 roots. Status 0 means no real roots,
// 1 one root (both root fields equal), 2 two roots, 3 a zero leading coefficient.
// Roots read zero for status 0 and 3.
// Between acceptance and its valid result a beat passes 89 registers: three front
// stages (capture, products, discriminant), 34 square root stages (an input
// register and 33 that settle one root bit each), 51 divider stages (an input
// register and 50 that settle one quotient bit each), and the output register.
// Throughput is one beat per cycle while the result channel is not stalled.
// Reset clears every valid bit; no result is pending afterward.
// When the receiver holds ready low on a waiting result, the whole pipeline
// freezes; the capture stage still takes one more beat if it is empty.
module quadratic_real_roots_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [qrr_pkg::DATA_W-1:0] in_coef_a,
  input  logic signed [qrr_pkg::DATA_W-1:0] in_coef_b,
  input  logic signed [qrr_pkg::DATA_W-1:0] in_coef_c,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_root_status,
  output logic signed [qrr_pkg::DATA_W-1:0] out_root_plus,
  output logic signed [qrr_pkg::DATA_W-1:0] out_root_minus
);

  localparam int DW = qrr_pkg::DATA_W;
  localparam int MW = qrr_pkg::MAG_W;

  logic adv;

  logic          v1_r;
  logic [DW-1:0] a1_r, b1_r, c1_r;

  logic                       v2_r;
  logic                       a_neg2_r, b_neg2_r, c_neg2_r;
  logic [MW-1:0]              a_mag2_r, b_mag2_r;
  logic [qrr_pkg::PROD_W-1:0] bsq2_r, mac2_r;

  logic [MW-1:0] a_mag1, b_mag1, c_mag1;

  logic                       v3_r;
  logic [qrr_pkg::DISC_W-1:0] d3_r;
  qrr_pkg::sq_side_t          side3_r;

  logic [qrr_pkg::DISC_W-1:0] d_nxt;
  qrr_pkg::sq_side_t          side_nxt;

  logic                        sq_v;
  logic [qrr_pkg::ROOT_W-1:0]  sq_s;
  qrr_pkg::sq_side_t           sq_side;

  logic [qrr_pkg::NUM_W-1:0]   np_s, nm_s, np_abs, nm_abs;
  logic [qrr_pkg::QUO_W-1:0]   dv_np, dv_nm;
  qrr_pkg::dv_side_t           dv_side_in;

  logic                        dv_v;
  logic [qrr_pkg::QUO_W-1:0]   dv_qp, dv_qm;
  qrr_pkg::dv_side_t           dv_side;

  logic                        out_valid_r;
  qrr_pkg::status_t            out_status_r;
  logic [DW-1:0]               out_plus_r, out_minus_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv || !v1_r;

  // Capture stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      a1_r <= in_coef_a;
      b1_r <= in_coef_b;
      c1_r <= in_coef_c;
    end
  end

  // Magnitudes and products.
  always_comb begin
    a_mag1 = a1_r[DW-1] ? (~a1_r + 1'b1) : a1_r;
    b_mag1 = b1_r[DW-1] ? (~b1_r + 1'b1) : b1_r;
    c_mag1 = c1_r[DW-1] ? (~c1_r + 1'b1) : c1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg2_r <= a1_r[DW-1];
      b_neg2_r <= b1_r[DW-1];
      c_neg2_r <= c1_r[DW-1];
      a_mag2_r <= a_mag1;
      b_mag2_r <= b_mag1;
      bsq2_r   <= b_mag1 * b_mag1;
      mac2_r   <= a_mag1 * c_mag1;
    end
  end

  // Discriminant and status.
  always_comb begin
    logic [qrr_pkg::DISC_W-1:0] bsq;
    logic [qrr_pkg::DISC_W-1:0] fac;
    logic [qrr_pkg::DISC_W-1:0] d;
    logic                       dneg;
    bsq  = {2'b00, bsq2_r};
    fac  = {mac2_r, 2'b00};
    dneg = 1'b0;
    if (a_neg2_r != c_neg2_r) begin
      d = bsq + fac;
    end else begin
      dneg = bsq < fac;
      d    = bsq - fac;
    end
    side_nxt.a_neg = a_neg2_r;
    side_nxt.a_mag = a_mag2_r;
    side_nxt.negb  = b_neg2_r ? $signed({1'b0, b_mag2_r}) : -$signed({1'b0, b_mag2_r});
    if (a_mag2_r == '0) begin
      side_nxt.status = qrr_pkg::ST_DEGEN;
    end else if (dneg) begin
      side_nxt.status = qrr_pkg::ST_NONE;
    end else if (d == '0) begin
      side_nxt.status = qrr_pkg::ST_ONE;
    end else begin
      side_nxt.status = qrr_pkg::ST_TWO;
    end
    d_nxt = (side_nxt.status == qrr_pkg::ST_TWO) ? d : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3_r    <= d_nxt;
      side3_r <= side_nxt;
    end
  end

  qrr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_in     (v3_r),
    .d_in     (d3_r),
    .side_in  (side3_r),
    .v_out    (sq_v),
    .s_out    (sq_s),
    .side_out (sq_side)
  );

  // Root numerators -b + s and -b - s, split into sign and magnitude.
  always_comb begin
    logic [qrr_pkg::NUM_W-1:0] nb;
    logic [qrr_pkg::NUM_W-1:0] sx;
    nb = {{(qrr_pkg::NUM_W - qrr_pkg::NEGB_W){sq_side.negb[qrr_pkg::NEGB_W-1]}},
          sq_side.negb};
    sx = {{(qrr_pkg::NUM_W - qrr_pkg::ROOT_W){1'b0}}, sq_s};
    np_s   = nb + sx;
    nm_s   = nb - sx;
    np_abs = np_s[qrr_pkg::NUM_W-1] ? (~np_s + 1'b1) : np_s;
    nm_abs = nm_s[qrr_pkg::NUM_W-1] ? (~nm_s + 1'b1) : nm_s;
    dv_np  = {np_abs[qrr_pkg::NMAG_W-1:0], {qrr_pkg::FRAC_W{1'b0}}};
    dv_nm  = {nm_abs[qrr_pkg::NMAG_W-1:0], {qrr_pkg::FRAC_W{1'b0}}};
    dv_side_in.status    = sq_side.status;
    dv_side_in.neg_plus  = np_s[qrr_pkg::NUM_W-1] != sq_side.a_neg;
    dv_side_in.neg_minus = nm_s[qrr_pkg::NUM_W-1] != sq_side.a_neg;
  end

  qrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_in     (sq_v),
    .np_in    (dv_np),
    .nm_in    (dv_nm),
    .den_in   ({sq_side.a_mag, 1'b0}),
    .side_in  (dv_side_in),
    .v_out    (dv_v),
    .qp_out   (dv_qp),
    .qm_out   (dv_qm),
    .side_out (dv_side)
  );

  // Output register with saturation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= dv_side.status;
      if (dv_side.status == qrr_pkg::ST_ONE || dv_side.status == qrr_pkg::ST_TWO) begin
        out_plus_r  <= qrr_pkg::sat_root(dv_qp, dv_side.neg_plus);
        out_minus_r <= qrr_pkg::sat_root(dv_qm, dv_side.neg_minus);
      end else begin
        out_plus_r  <= '0;
        out_minus_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_status = out_status_r;
  assign out_root_plus   = out_plus_r;
  assign out_root_minus  = out_minus_r;

  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_single_root_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_root_status != qrr_pkg::ST_TWO) |-> (out_root_minus == out_root_plus))
    else $error("root fields differ on a result without two roots");

  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_root_status == qrr_pkg::ST_NONE ||
                   out_root_status == qrr_pkg::ST_DEGEN)) |-> (out_root_plus == '0))
    else $error("nonzero root on a result without real roots");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_root_plus) &&
                                   $stable(out_root_status)))
    else $error("waiting result changed");

endmodule
